/* rtl/jvcm_pkg.sv */
// Shared types and constants for the joystick vehicle command mapper.
`default_nettype none

package jvcm_pkg;

   // Register reset values
   localparam logic [15:0] BRAKE_SPAN_RESET     = 16'd6656;
   localparam logic [15:0] THROTTLE_SPAN_RESET  = 16'd50;
   localparam logic [14:0] STEER_SPAN_RESET     = 15'd15000;
   localparam logic [14:0] STICK_DEADZONE_RESET = 15'd200;

   // Gear positions: park .. high
   localparam logic [2:0] GEAR_PARK = 3'd0;
   localparam logic [2:0] GEAR_HIGH = 3'd4;

   // Request queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Message kinds, also the bit positions of the pending-message mask
   typedef enum logic [2:0] {
      KIND_THROTTLE = 3'd0,
      KIND_STEER    = 3'd1,
      KIND_BRAKE    = 3'd2,
      KIND_GEAR     = 3'd3,
      KIND_STOP     = 3'd4
   } msg_kind_type;

   localparam int KIND_COUNT = 5;

   // Register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_BRAKE_SPAN     = 2'd0,
      REG_THROTTLE_SPAN  = 2'd1,
      REG_STEER_SPAN     = 2'd2,
      REG_STICK_DEADZONE = 2'd3
   } reg_index_type;

   // One classified request: which messages to send and their values
   typedef struct packed {
      logic [KIND_COUNT-1:0] mask;
      logic [15:0]           throttle;
      logic signed [15:0]    steer;
      logic [15:0]           brake;
      logic [2:0]            gear;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/jvcm_front.sv */
// Front end: scales a gamepad request, updates held commands and classifies messages.
`default_nettype none

module jvcm_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic signed [15:0]  req_stick_x,
   input  wire logic signed [15:0]  req_left_trigger,
   input  wire logic signed [15:0]  req_right_trigger,
   input  wire logic                req_start_pressed,
   input  wire logic                req_left_bumper,
   input  wire logic                req_right_bumper,
   input  wire logic                push,
   output logic                     full,
   input  wire logic [15:0]         brake_span,
   input  wire logic [15:0]         throttle_span,
   input  wire logic [14:0]         steer_span,
   input  wire logic [14:0]         stick_deadzone,
   input  wire logic                q_full,
   output logic                     q_push,
   output jvcm_pkg::entry_type      q_data
);
   import jvcm_pkg::*;

   // floor(p / 65535) for p below 65535^2: one estimate, one correction
   function automatic logic [15:0] div65535(input logic [31:0] p);
      logic [15:0] q;
      logic [16:0] r;
      q = p[31:16];
      r = {1'b0, p[15:0]} + {1'b0, q};
      if (r >= 17'd65535) begin
         q = q + 16'd1;
      end
      return q;
   endfunction

   // floor(p / 32767) for p up to 32768*32767
   function automatic logic [15:0] div32767(input logic [30:0] p);
      logic [15:0] q;
      logic [15:0] r;
      q = p[30:15];
      r = {1'b0, p[14:0]} + q;
      if (r >= 16'd32767) begin
         q = q + 16'd1;
      end
      return q;
   endfunction

   // Trigger offset, floored at zero
   function automatic logic [15:0] trig_level(input logic signed [15:0] raw);
      logic signed [16:0] s;
      s = 17'(raw) + 17'sd32767;
      return s[16] ? 16'd0 : s[15:0];
   endfunction

   logic               accept;
   logic               s1_fire;
   logic [15:0]        lt_level;
   logic [15:0]        rt_level;
   logic [15:0]        stick_mag;

   // Stage 1 registers: products and flags
   logic               s1_valid_ff, s1_valid_in;
   logic [31:0]        prod_brake_ff;
   logic [31:0]        prod_throttle_ff;
   logic [30:0]        prod_steer_ff;
   logic               steer_neg_ff;
   logic               steer_upd_ff;
   logic               start_ff;
   logic               lb_ff;
   logic               rb_ff;

   // Held command state
   logic [15:0]        held_throttle_ff, held_throttle_in;
   logic [15:0]        held_brake_ff, held_brake_in;
   logic signed [15:0] held_steer_ff, held_steer_in;
   logic [2:0]         gear_ff, gear_in;
   logic               prev_lb_ff;
   logic               prev_rb_ff;
   logic               first_done_ff;

   logic [15:0]        steer_q;
   logic [KIND_COUNT-1:0] mask;

   assign accept      = push && !full;
   assign s1_fire     = s1_valid_ff && !q_full;
   assign full        = s1_valid_ff && q_full;
   assign lt_level    = trig_level(req_left_trigger);
   assign rt_level    = trig_level(req_right_trigger);
   assign stick_mag   = req_stick_x[15] ? 16'(16'd0 - req_stick_x) : req_stick_x;
   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   // Stage 1: multiply by the configured full-scale values
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         prod_brake_ff    <= 32'(lt_level) * 32'(brake_span);
         prod_throttle_ff <= 32'(rt_level) * 32'(throttle_span);
         prod_steer_ff    <= 31'(stick_mag) * 31'(steer_span);
         steer_neg_ff     <= req_stick_x[15];
         steer_upd_ff     <= stick_mag > {1'b0, stick_deadzone};
         start_ff         <= req_start_pressed;
         lb_ff            <= req_left_bumper;
         rb_ff            <= req_right_bumper;
      end
   end

   // Stage 2: finish the divisions, shift gear, compare with held values
   always_comb begin
      held_throttle_in = div65535(prod_throttle_ff);
      held_brake_in    = div65535(prod_brake_ff);
      steer_q          = div32767(prod_steer_ff);
      held_steer_in    = held_steer_ff;
      if (steer_upd_ff) begin
         held_steer_in = steer_neg_ff ? signed'(16'(16'd0 - steer_q)) : signed'(steer_q);
      end

      gear_in = gear_ff;
      if ((rb_ff != prev_rb_ff) || (lb_ff != prev_lb_ff)) begin
         if (rb_ff && (gear_ff < GEAR_HIGH) && (held_throttle_in == 16'd0)) begin
            gear_in = gear_ff + 3'd1;
         end else if (lb_ff && (gear_ff > GEAR_PARK) && (held_throttle_in == 16'd0)) begin
            gear_in = gear_ff - 3'd1;
         end
      end

      mask = '0;
      if (first_done_ff) begin
         mask[KIND_THROTTLE] = held_throttle_in != held_throttle_ff;
         mask[KIND_STEER]    = held_steer_in != held_steer_ff;
         mask[KIND_BRAKE]    = held_brake_in != held_brake_ff;
         mask[KIND_GEAR]     = gear_in != gear_ff;
      end
      mask[KIND_STOP] = start_ff;
   end

   assign q_push          = s1_fire && (mask != '0);
   assign q_data.mask     = mask;
   assign q_data.throttle = held_throttle_in;
   assign q_data.steer    = held_steer_in;
   assign q_data.brake    = held_brake_in;
   assign q_data.gear     = gear_in;

   // Held state advances as each request leaves stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         held_throttle_ff <= '0;
         held_brake_ff    <= '0;
         held_steer_ff    <= '0;
         gear_ff          <= GEAR_PARK;
         prev_lb_ff       <= 1'b0;
         prev_rb_ff       <= 1'b0;
         first_done_ff    <= 1'b0;
      end else if (s1_fire) begin
         held_throttle_ff <= held_throttle_in;
         held_brake_ff    <= held_brake_in;
         held_steer_ff    <= held_steer_in;
         gear_ff          <= gear_in;
         prev_lb_ff       <= lb_ff;
         prev_rb_ff       <= rb_ff;
         first_done_ff    <= 1'b1;
      end
   end

   // Gear never leaves the table
   a_gear_range: assert property (@(posedge clock) disable iff (reset)
      gear_ff <= GEAR_HIGH)
      else $error("gear index out of range");

   // Only a stop message may follow the first request
   a_first_stop_only: assert property (@(posedge clock) disable iff (reset)
      (q_push && !first_done_ff) |-> (q_data.mask[KIND_STOP] && q_data.mask[3:0] == 4'd0))
      else $error("first request produced a change message");

endmodule

`default_nettype wire

/* rtl/jvcm_queue.sv */
// Short request queue between the front and back ends.
`default_nettype none

module jvcm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire jvcm_pkg::entry_type wr_data,
   output logic                     q_full,
   input  wire logic                rd_en,
   output jvcm_pkg::entry_type      rd_data,
   output logic                     q_empty
);
   import jvcm_pkg::*;

   entry_type         slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign q_full    = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign q_empty   = count_ff == '0;
   assign rd_data   = slots_ff[rd_ptr_ff];
   assign wr_ptr_in = wr_en ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
   assign rd_ptr_in = rd_en ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && q_full && !rd_en))
      else $error("write into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && q_empty))
      else $error("read from empty queue");

   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      QPTR_W'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

/* rtl/jvcm_back.sv */
// Back end: sends the messages of each queued request one per cycle while pop takes them.
`default_nettype none

module jvcm_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire jvcm_pkg::entry_type head,
   input  wire logic                q_empty,
   output logic                     q_pop,
   output logic                     rsp_valid,
   output logic [2:0]               rsp_msg_kind,
   output logic signed [16:0]       rsp_msg_value,
   output logic                     rsp_last_msg,
   input  wire logic                pop
);
   import jvcm_pkg::*;

   // Gear position to its command value
   function automatic logic signed [16:0] gear_value(input logic [2:0] idx);
      logic signed [16:0] v;
      case (idx)
         3'd0:    v = 17'sd0;
         3'd1:    v = -17'sd14336;
         3'd2:    v = -17'sd26624;
         3'd3:    v = -17'sd32768;
         3'd4:    v = -17'sd49152;
         default: v = 17'sd0;
      endcase
      return v;
   endfunction

   logic [KIND_COUNT-1:0] sent_ff, sent_in;
   logic                  valid_ff, valid_in;
   logic [2:0]            kind_ff;
   logic signed [16:0]    value_ff;
   logic                  last_ff;

   logic [KIND_COUNT-1:0] remaining;
   logic [KIND_COUNT-1:0] pick;
   msg_kind_type          kind;
   logic signed [16:0]    value;
   logic                  is_last;
   logic                  load;
   logic                  take;

   assign take      = pop && valid_ff;
   assign load      = !q_empty && (!valid_ff || take);
   assign remaining = head.mask & ~sent_ff;

   // Fixed priority among pending messages: throttle, steer, brake, gear, stop
   always_comb begin
      if (remaining[KIND_THROTTLE]) begin
         kind  = KIND_THROTTLE;
         value = signed'({1'b0, head.throttle});
      end else if (remaining[KIND_STEER]) begin
         kind  = KIND_STEER;
         value = 17'(head.steer);
      end else if (remaining[KIND_BRAKE]) begin
         kind  = KIND_BRAKE;
         value = signed'({1'b0, head.brake});
      end else if (remaining[KIND_GEAR]) begin
         kind  = KIND_GEAR;
         value = gear_value(head.gear);
      end else begin
         kind  = KIND_STOP;
         value = 17'sd0;
      end
      pick       = '0;
      pick[kind] = 1'b1;
      is_last    = (remaining & ~pick) == '0;
   end

   assign q_pop    = load && is_last;
   assign sent_in  = load ? (is_last ? '0 : (sent_ff | pick)) : sent_ff;
   assign valid_in = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   // Output register and progress through the head request
   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         kind_ff  <= 3'(kind);
         value_ff <= value;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_msg_kind  = kind_ff;
   assign rsp_msg_value = value_ff;
   assign rsp_last_msg  = last_ff;

   // Progress only names messages that the head request carries
   a_sent_subset: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> ((sent_ff & ~head.mask) == '0))
      else $error("sent mask outside head request");

   a_sent_idle_clear: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> (sent_ff == '0))
      else $error("progress left over with empty queue");

endmodule

`default_nettype wire

/* rtl/joystick_vehicle_command_mapper.sv */
// Top level of the joystick vehicle command mapper: register file and front/queue/back.
//
//   channel   direction  handshake               payload
//   req_*     in         push / full             stick_x, left/right_trigger, start, bumpers
//   rsp_*     out        empty / pop             msg_kind, msg_value, last_msg
//   csr       in/out     psel, penable, pwrite   paddr[3:2] selects 4 registers, pwdata, prdata
//
// A request is registered in the multiply stage and leaves the front when the queue has room;
// the front takes a new request every cycle while the queue has room.
// The back end sends one message per cycle while pop takes them; a request carries up to 5
// messages, and the first one passes the stage-1 register, a queue slot and the output register.
// Reset is synchronous; it empties the pipeline and queue and loads register defaults.
// A held rsp message never stalls the front until the 4-entry queue fills.
`default_nettype none

module joystick_vehicle_command_mapper (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic signed [15:0]  req_stick_x,
   input  wire logic signed [15:0]  req_left_trigger,
   input  wire logic signed [15:0]  req_right_trigger,
   input  wire logic                req_start_pressed,
   input  wire logic                req_left_bumper,
   input  wire logic                req_right_bumper,
   input  wire logic                push,
   output logic                     full,
   // response channel
   output logic [2:0]               rsp_msg_kind,
   output logic signed [16:0]       rsp_msg_value,
   output logic                     rsp_last_msg,
   output logic                     empty,
   input  wire logic                pop,
   // configuration port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [3:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   import jvcm_pkg::*;

   logic [15:0]   brake_span_ff;
   logic [15:0]   throttle_span_ff;
   logic [14:0]   steer_span_ff;
   logic [14:0]   stick_deadzone_ff;
   reg_index_type reg_sel;
   logic          csr_write;

   logic          q_full;
   logic          q_push;
   logic          q_pop;
   logic          q_empty;
   entry_type     q_wr_data;
   entry_type     q_head;
   logic          rsp_valid;

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         brake_span_ff     <= BRAKE_SPAN_RESET;
         throttle_span_ff  <= THROTTLE_SPAN_RESET;
         steer_span_ff     <= STEER_SPAN_RESET;
         stick_deadzone_ff <= STICK_DEADZONE_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            REG_BRAKE_SPAN:     brake_span_ff     <= pwdata[15:0];
            REG_THROTTLE_SPAN:  throttle_span_ff  <= pwdata[15:0];
            REG_STEER_SPAN:     steer_span_ff     <= pwdata[14:0];
            REG_STICK_DEADZONE: stick_deadzone_ff <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      case (reg_sel)
         REG_BRAKE_SPAN:     prdata = {16'd0, brake_span_ff};
         REG_THROTTLE_SPAN:  prdata = {16'd0, throttle_span_ff};
         REG_STEER_SPAN:     prdata = {17'd0, steer_span_ff};
         REG_STICK_DEADZONE: prdata = {17'd0, stick_deadzone_ff};
         default:            prdata = '0;
      endcase
   end

   jvcm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_stick_x       (req_stick_x),
      .req_left_trigger  (req_left_trigger),
      .req_right_trigger (req_right_trigger),
      .req_start_pressed (req_start_pressed),
      .req_left_bumper   (req_left_bumper),
      .req_right_bumper  (req_right_bumper),
      .push              (push),
      .full              (full),
      .brake_span        (brake_span_ff),
      .throttle_span     (throttle_span_ff),
      .steer_span        (steer_span_ff),
      .stick_deadzone    (stick_deadzone_ff),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_data            (q_wr_data)
   );

   jvcm_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .q_empty (q_empty)
   );

   jvcm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_msg_kind  (rsp_msg_kind),
      .rsp_msg_value (rsp_msg_value),
      .rsp_last_msg  (rsp_last_msg),
      .pop           (pop)
   );

   assign empty = !rsp_valid;

endmodule

`default_nettype wire
